// ===== hw/rtl/lmsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix scan package
// Shared types, operation codes and the pixel placement table of the
// multiplexed LED matrix scan driver.
// ----------------------------------------------------------------------------
package lmsp_pkg;

  localparam int VIS_SIZE = 5;
  localparam int IMG_BITS = VIS_SIZE * VIS_SIZE;
  localparam int HW_ROWS  = 3;
  localparam int HW_COLS  = 9;

  localparam logic [15:0]        PERIOD_RESET = 16'd6000;
  localparam logic [HW_COLS-1:0] COLS_OFF     = '1;

  // Operation codes of the input item.
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_PIXEL_ON  = 3'd1;
  localparam logic [2:0] OP_PIXEL_OFF = 3'd2;
  localparam logic [2:0] OP_LOAD      = 3'd3;
  localparam logic [2:0] OP_SHIFT     = 3'd4;

  // Electrical row and column of each visible pixel, indexed by row*5+col.
  localparam logic [1:0] PLACE_ROW [IMG_BITS] = '{
    2'd0, 2'd1, 2'd0, 2'd1, 2'd0,
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd0, 2'd1, 2'd2, 2'd1,
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
    2'd2, 2'd1, 2'd2, 2'd1, 2'd2
  };

  localparam logic [3:0] PLACE_COL [IMG_BITS] = '{
    4'd0, 4'd3, 4'd1, 4'd4, 4'd2,
    4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd1, 4'd8, 4'd2, 4'd8, 4'd0,
    4'd7, 4'd6, 4'd5, 4'd4, 4'd3,
    4'd2, 4'd6, 4'd0, 4'd5, 4'd1
  };

  // One result item.
  typedef struct packed {
    logic [HW_ROWS-1:0] row_enable;
    logic [HW_COLS-1:0] col_levels;
    logic [1:0]         scan_row;
  } res_t;

endpackage

// ===== hw/rtl/lmsp_colmap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix scan column map
// Builds the active-low column levels of one electrical row from the image.
// ----------------------------------------------------------------------------
module lmsp_colmap
  import lmsp_pkg::*;
(
  input  logic [IMG_BITS-1:0] image,
  input  logic [1:0]          row,
  output logic [HW_COLS-1:0]  col_levels
);

  always_comb begin
    col_levels = COLS_OFF;
    for (int v = 0; v < IMG_BITS; v++) begin
      if (image[v] && (PLACE_ROW[v] == row)) begin
        col_levels[PLACE_COL[v]] = 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/lmsp_state.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix scan state
// Holds the image, tick counter and latched row drive, and computes the
// state after each item.
// ----------------------------------------------------------------------------
module lmsp_state
  import lmsp_pkg::*;
#(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [2:0]          op,
  input  logic [2:0]          pixel_row,
  input  logic [2:0]          pixel_col,
  input  logic [IMG_BITS-1:0] image_bits,
  input  logic [4:0]          new_column,
  input  logic [15:0]         refresh_period,
  output res_t                res
);

  localparam int CMP_W = (COUNTER_WIDTH + 1 > 17) ? COUNTER_WIDTH + 1 : 17;

  logic [IMG_BITS-1:0]      image_r, image_nxt;
  logic [COUNTER_WIDTH-1:0] tick_r, tick_nxt;
  logic [1:0]               row_index_r, row_index_nxt;
  logic [HW_ROWS-1:0]       row_drive_r, row_drive_nxt;
  logic [HW_COLS-1:0]       col_drive_r, col_drive_nxt;

  logic [COUNTER_WIDTH:0]   tick_inc;
  logic                     advance;
  logic [1:0]               row_adv;
  logic [HW_COLS-1:0]       cols_adv;
  logic                     pix_ok;
  logic [4:0]               pix_idx;
  logic [IMG_BITS-1:0]      pix_mask;
  logic [IMG_BITS-1:0]      shifted;

  lmsp_colmap u_colmap (
    .image      (image_r),
    .row        (row_adv),
    .col_levels (cols_adv)
  );

  // A count that would run past the counter's range advances the row too.
  assign tick_inc = {1'b0, tick_r} + {{COUNTER_WIDTH{1'b0}}, 1'b1};
  assign advance  = (CMP_W'(tick_inc) >= CMP_W'(refresh_period)) || tick_inc[COUNTER_WIDTH];
  assign row_adv  = (row_index_r == 2'(HW_ROWS - 1)) ? 2'd0 : row_index_r + 2'd1;

  assign pix_ok   = (pixel_row < 3'(VIS_SIZE)) && (pixel_col < 3'(VIS_SIZE));
  assign pix_idx  = 5'(pixel_row) * 5'(VIS_SIZE) + 5'(pixel_col);
  assign pix_mask = IMG_BITS'(1) << pix_idx;

  // Each visible row moves one column left; the new column enters at the right.
  always_comb begin
    for (int r = 0; r < VIS_SIZE; r++) begin
      for (int c = 0; c < VIS_SIZE - 1; c++) begin
        shifted[r*VIS_SIZE + c] = image_r[r*VIS_SIZE + c + 1];
      end
      shifted[r*VIS_SIZE + VIS_SIZE - 1] = new_column[r];
    end
  end

  always_comb begin
    image_nxt     = image_r;
    tick_nxt      = tick_r;
    row_index_nxt = row_index_r;
    row_drive_nxt = row_drive_r;
    col_drive_nxt = col_drive_r;
    unique case (op)
      OP_TICK: begin
        if (advance) begin
          tick_nxt      = '0;
          row_index_nxt = row_adv;
          row_drive_nxt = HW_ROWS'(1) << row_adv;
          col_drive_nxt = cols_adv;
        end else begin
          tick_nxt = tick_inc[COUNTER_WIDTH-1:0];
        end
      end
      OP_PIXEL_ON: begin
        if (pix_ok) begin
          image_nxt = image_r | pix_mask;
        end
      end
      OP_PIXEL_OFF: begin
        if (pix_ok) begin
          image_nxt = image_r & ~pix_mask;
        end
      end
      OP_LOAD: begin
        image_nxt = image_bits;
      end
      OP_SHIFT: begin
        image_nxt = shifted;
      end
      default: begin
        image_nxt = image_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_r     <= '0;
      tick_r      <= '0;
      row_index_r <= '0;
      row_drive_r <= '0;
      col_drive_r <= COLS_OFF;
    end else if (accept) begin
      image_r     <= image_nxt;
      tick_r      <= tick_nxt;
      row_index_r <= row_index_nxt;
      row_drive_r <= row_drive_nxt;
      col_drive_r <= col_drive_nxt;
    end
  end

  assign res.row_enable = row_drive_nxt;
  assign res.col_levels = col_drive_nxt;
  assign res.scan_row   = row_index_nxt;

  // The row drive is either all off or selects exactly the indexed row.
  a_row_drive_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (row_drive_r != '0) |-> (row_drive_r == (HW_ROWS'(1) << row_index_r)))
    else $error("row drive does not match row index");

  // Before the first row advance nothing is driven.
  a_idle_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (row_drive_r == '0) |-> ((col_drive_r == COLS_OFF) && (row_index_r == 2'd0)))
    else $error("columns driven before the first row advance");

endmodule

// ===== hw/rtl/lmsp_outbuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix scan output buffer
// Output register with a skid stage so the input side never waits on the
// output stall directly.
// ----------------------------------------------------------------------------
module lmsp_outbuf
  import lmsp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t din,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output res_t dout
);

  logic out_valid_r, skid_valid_r;
  res_t out_r, skid_r;
  logic pop;

  assign pop = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_r <= din;
      end else begin
        out_r <= din;
      end
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign dout      = out_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds an item while the output is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> (!skid_valid_r && out_valid_r))
    else $error("skid stage did not drain when the output moved");

endmodule

// ===== hw/rtl/led_matrix_scan_with_pixel_map_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix scan driver core
// Keeps a 5x5 image and scans it onto a 3-row by 9-column LED matrix.
// ----------------------------------------------------------------------------
// Each input item carries one operation: a time tick, pixel on, pixel off,
// a whole-image load or a one-column left shift with a new right column.
// Pixel operations with a row or column of 5 or more change nothing, and the
// unused operation codes change nothing either. Every accepted item yields
// exactly one result item: the latched one-hot row enable, the active-low
// column levels of that row and the scan row index, all taken after the
// item's own update. Image changes reach the outputs only at the next row
// advance, on the tick that brings the count to refresh_period. The whole
// update is one combinational step from the state registers into the output
// buffer, so an item is accepted every cycle unless stalled. A two-entry
// buffer (output register plus a skid stage) lets the block take a new item
// while a result still waits; in_stall rises only once both entries are full.
// Reset clears the image and the counter, turns all rows and columns off and
// loads a refresh period of 6000 ticks. The user must write the refresh
// period through cfg_wr_en only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module led_matrix_scan_with_pixel_map_core
  import lmsp_pkg::*;
#(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_op,
  input  logic [2:0]          in_pixel_row,
  input  logic [2:0]          in_pixel_col,
  input  logic [IMG_BITS-1:0] in_image_bits,
  input  logic [4:0]          in_new_column,

  output logic                out_valid,
  input  logic                out_stall,
  output logic [HW_ROWS-1:0]  out_row_enable,
  output logic [HW_COLS-1:0]  out_col_levels,
  output logic [1:0]          out_scan_row
);

  logic [15:0] refresh_period_r;
  logic        accept;
  logic        buf_full;
  res_t        res_new;
  res_t        res_out;

  // The single configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refresh_period_r <= PERIOD_RESET;
    end else if (cfg_wr_en) begin
      refresh_period_r <= cfg_wr_data;
    end
  end

  // An item enters whenever the skid stage has room.
  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  lmsp_state #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_state (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .op             (in_op),
    .pixel_row      (in_pixel_row),
    .pixel_col      (in_pixel_col),
    .image_bits     (in_image_bits),
    .new_column     (in_new_column),
    .refresh_period (refresh_period_r),
    .res            (res_new)
  );

  lmsp_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .din       (res_new),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (res_out)
  );

  assign out_row_enable = res_out.row_enable;
  assign out_col_levels = res_out.col_levels;
  assign out_scan_row   = res_out.scan_row;

endmodule
